@@ rtl/ask4_psd_pkg.sv @@
// Shared types and constants for the four-level ASK peak symbol detector.
// No dependencies; used by every module in rtl/.
package ask4_psd_pkg;

    localparam int unsigned SampleWidth = 10;
    localparam int unsigned SymbolWidth = 2;
    localparam int unsigned CfgAddrWidth = 3;

    typedef logic [SampleWidth-1:0] sample_t;
    typedef logic [SymbolWidth-1:0] symbol_t;
    typedef logic [CfgAddrWidth-1:0] cfg_addr_t;

    // Register indexes on the configuration port
    typedef enum logic [CfgAddrWidth-1:0] {
        REG_SLOPE_THR = 3'd0,
        REG_L0_LOW    = 3'd1,
        REG_L0_HIGH   = 3'd2,
        REG_L1_LOW    = 3'd3,
        REG_L1_HIGH   = 3'd4,
        REG_L2_LOW    = 3'd5,
        REG_L2_HIGH   = 3'd6,
        REG_L3_LOW    = 3'd7
    } cfg_reg_t;

    localparam sample_t SlopeThrRst = 10'd80;
    localparam sample_t L0LowRst    = 10'd200;
    localparam sample_t L0HighRst   = 10'd300;
    localparam sample_t L1LowRst    = 10'd400;
    localparam sample_t L1HighRst   = 10'd550;
    localparam sample_t L2LowRst    = 10'd650;
    localparam sample_t L2HighRst   = 10'd800;
    localparam sample_t L3LowRst    = 10'd900;

    localparam symbol_t Sym0 = 2'd0;
    localparam symbol_t Sym1 = 2'd1;
    localparam symbol_t Sym2 = 2'd2;
    localparam symbol_t Sym3 = 2'd3;

    typedef struct packed {
        sample_t slope_thr;
        sample_t l0_low;
        sample_t l0_high;
        sample_t l1_low;
        sample_t l1_high;
        sample_t l2_low;
        sample_t l2_high;
        sample_t l3_low;
    } cfg_t;

    // Tracker to classifier: end of an armed pulse and its peak
    typedef struct packed {
        logic    fire;
        sample_t peak;
    } pulse_t;

endpackage

@@ rtl/ask4_cfg_regs.sv @@
// Configuration register file: slope threshold and amplitude window bounds.
// Depends on ask4_psd_pkg.
module ask4_cfg_regs (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  ask4_psd_pkg::cfg_addr_t cfg_addr,
    input  ask4_psd_pkg::sample_t  cfg_wdata,
    output ask4_psd_pkg::cfg_t     cfg
);

    ask4_psd_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.slope_thr <= ask4_psd_pkg::SlopeThrRst;
            cfg_reg.l0_low    <= ask4_psd_pkg::L0LowRst;
            cfg_reg.l0_high   <= ask4_psd_pkg::L0HighRst;
            cfg_reg.l1_low    <= ask4_psd_pkg::L1LowRst;
            cfg_reg.l1_high   <= ask4_psd_pkg::L1HighRst;
            cfg_reg.l2_low    <= ask4_psd_pkg::L2LowRst;
            cfg_reg.l2_high   <= ask4_psd_pkg::L2HighRst;
            cfg_reg.l3_low    <= ask4_psd_pkg::L3LowRst;
        end else if (cfg_wr_en) begin
            unique case (ask4_psd_pkg::cfg_reg_t'(cfg_addr))
                ask4_psd_pkg::REG_SLOPE_THR: cfg_reg.slope_thr <= cfg_wdata;
                ask4_psd_pkg::REG_L0_LOW:    cfg_reg.l0_low    <= cfg_wdata;
                ask4_psd_pkg::REG_L0_HIGH:   cfg_reg.l0_high   <= cfg_wdata;
                ask4_psd_pkg::REG_L1_LOW:    cfg_reg.l1_low    <= cfg_wdata;
                ask4_psd_pkg::REG_L1_HIGH:   cfg_reg.l1_high   <= cfg_wdata;
                ask4_psd_pkg::REG_L2_LOW:    cfg_reg.l2_low    <= cfg_wdata;
                ask4_psd_pkg::REG_L2_HIGH:   cfg_reg.l2_high   <= cfg_wdata;
                ask4_psd_pkg::REG_L3_LOW:    cfg_reg.l3_low    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/ask4_peak_tracker.sv @@
// Edge detection, arming and peak tracking over the sample stream.
// Depends on ask4_psd_pkg.
module ask4_peak_tracker (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  ask4_psd_pkg::sample_t sample,
    input  ask4_psd_pkg::sample_t slope_thr,
    output ask4_psd_pkg::pulse_t  pulse
);

    ask4_psd_pkg::sample_t prev_reg, prev_next;
    ask4_psd_pkg::sample_t peak_reg, peak_next;
    logic                  armed_reg, armed_next;

    logic [ask4_psd_pkg::SampleWidth:0] rise_diff;
    ask4_psd_pkg::sample_t              fall_diff;
    ask4_psd_pkg::sample_t              peak_mid;
    logic                               rise;
    logic                               arm_now;
    logic                               armed_mid;
    logic                               fall;

    always_comb begin
        rise_diff = {1'b0, sample} - {1'b0, prev_reg};
        // positive difference only; a negative one never counts as a rise
        rise      = !rise_diff[ask4_psd_pkg::SampleWidth] &&
                    (rise_diff[ask4_psd_pkg::SampleWidth-1:0] > slope_thr);
        arm_now   = rise && !armed_reg;
        armed_mid = armed_reg || arm_now;
        peak_mid  = arm_now ? '0 : peak_reg;
        peak_next = (sample > peak_mid) ? sample : peak_mid;
        // peak_next never drops below sample, so the difference cannot wrap
        fall_diff = peak_next - sample;
        fall      = fall_diff > slope_thr;
        armed_next = armed_mid && !fall;
        prev_next  = sample;
        pulse.fire = armed_mid && fall;
        pulse.peak = peak_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg  <= '0;
            peak_reg  <= '0;
            armed_reg <= 1'b0;
        end else if (step) begin
            prev_reg  <= prev_next;
            peak_reg  <= peak_next;
            armed_reg <= armed_next;
        end
    end

endmodule

@@ rtl/ask4_classifier.sv @@
// Window classification of a pulse peak into one of four symbols.
// Depends on ask4_psd_pkg.
module ask4_classifier (
    input  ask4_psd_pkg::sample_t peak,
    input  ask4_psd_pkg::cfg_t    cfg,
    output logic                  hit,
    output ask4_psd_pkg::symbol_t symbol
);

    logic in0, in1, in2, in3;

    always_comb begin
        in0 = (peak > cfg.l0_low) && (peak < cfg.l0_high);
        in1 = (peak > cfg.l1_low) && (peak < cfg.l1_high);
        in2 = (peak > cfg.l2_low) && (peak < cfg.l2_high);
        in3 = peak > cfg.l3_low;
        hit = in0 || in1 || in2 || in3;
        // lowest window wins where windows overlap
        if (in0) begin
            symbol = ask4_psd_pkg::Sym0;
        end else if (in1) begin
            symbol = ask4_psd_pkg::Sym1;
        end else if (in2) begin
            symbol = ask4_psd_pkg::Sym2;
        end else begin
            symbol = ask4_psd_pkg::Sym3;
        end
    end

endmodule

@@ rtl/ask4_peak_symbol_detector_core.sv @@
// Four-level ASK peak symbol detector, top level.
// The input register holds the sample; the result register then holds its symbol (if any).
// Throughput: one sample per cycle; the input register advances whenever the
// result register is empty or being taken. Samples that end no pulse give no beat.
// Reset (aresetn, synchronous, active low) clears the pipeline, the tracker state
// and loads the default threshold and window bounds.
module ask4_peak_symbol_detector_core (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  ask4_psd_pkg::sample_t   s_sample,
    output logic                    m_valid,
    input  logic                    m_ready,
    output ask4_psd_pkg::symbol_t   m_symbol,
    input  logic                    cfg_wr_en,
    input  ask4_psd_pkg::cfg_addr_t cfg_addr,
    input  ask4_psd_pkg::sample_t   cfg_wdata
);

    ask4_psd_pkg::cfg_t    cfg;
    ask4_psd_pkg::pulse_t  pulse;
    ask4_psd_pkg::sample_t in_sample_reg;
    ask4_psd_pkg::symbol_t out_symbol_reg;
    logic                  in_valid_reg;
    logic                  out_valid_reg;
    logic                  advance;
    logic                  hit;
    ask4_psd_pkg::symbol_t symbol;

    ask4_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .cfg      (cfg)
    );

    ask4_peak_tracker u_tracker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (advance),
        .sample   (in_sample_reg),
        .slope_thr(cfg.slope_thr),
        .pulse    (pulse)
    );

    ask4_classifier u_class (
        .peak  (pulse.peak),
        .cfg   (cfg),
        .hit   (hit),
        .symbol(symbol)
    );

    // move the held sample through the tracker when the result slot is free
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_sample_reg <= s_sample;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= pulse.fire && hit;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_symbol_reg <= symbol;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_symbol = out_symbol_reg;

endmodule
